FILE: hw/rtl/psv_pkg.sv
// psv_pkg: constants, byte codes and the beat types shared by the path validator
// modules. It has no dependencies.
`timescale 1ns / 1ps

package psv_pkg;

   // path limits
   localparam int MAX_PATH_BYTES = 256;
   localparam int MAX_NAME_BYTES = 240;
   localparam int COUNT_W        = $clog2(MAX_PATH_BYTES + 1);

   // upload prefix and suffix
   localparam int PREFIX_LEN   = 18;
   localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
   localparam int SUFFIX_LEN   = 5;
   localparam int TAIL_W       = 8 * SUFFIX_LEN;
   localparam logic [TAIL_W-1:0] SUFFIX_CODE = 40'h2E68746D6C;   // ".html"
   localparam int CMP_W = $clog2(MAX_PATH_BYTES + PREFIX_LEN + MAX_NAME_BYTES + 1);

   localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{
      8'h2F, 8'h65, 8'h76, 8'h69, 8'h6C, 8'h5F, 8'h70, 8'h6F, 8'h72,
      8'h74, 8'h61, 8'h6C, 8'h2F, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h2F
   };

   // byte codes
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // mode codes
   localparam logic MODE_GENERAL = 1'b0;
   localparam logic MODE_UPLOAD  = 1'b1;

   // one path byte presented to the checker
   typedef struct packed {
      logic       valid;
      logic [7:0] char_in;
      logic       last;
   } step_type;

   // verdict from the checker
   typedef struct packed {
      logic valid;
      logic valid_res;
   } verdict_type;

endpackage

FILE: hw/rtl/psv_checker.sv
// psv_checker: per-path state and verdict logic for the path validator.
// Depends on psv_pkg.
`timescale 1ns / 1ps

module psv_checker
   import psv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        mode,
   input  step_type    step,
   output verdict_type verdict
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         part_len_ff, part_len_in;
   logic               part_dots_ff, part_dots_in;
   logic               fault_ff, fault_in;
   logic               prefix_ok_ff, prefix_ok_in;
   logic               name_slash_ff, name_slash_in;
   logic [TAIL_W-1:0]  tail_ff, tail_in;

   // next state and verdict for the byte in the input stage
   always_comb begin
      logic [7:0]       c;
      logic [1:0]       plen;
      logic             pdots;
      logic             flt;
      logic [CMP_W-1:0] len;
      logic             ok;
      c     = step.char_in;
      plen  = part_len_ff;
      pdots = part_dots_ff;
      flt   = fault_ff;
      len   = '0;
      ok    = 1'b0;

      count_in      = count_ff;
      prefix_ok_in  = prefix_ok_ff;
      name_slash_in = name_slash_ff;
      tail_in       = tail_ff;
      verdict.valid     = 1'b0;
      verdict.valid_res = 1'b0;

      if (step.valid) begin
         // prefix compare, slash after the prefix
         if (count_ff < COUNT_W'(PREFIX_LEN)) begin
            if (c != PREFIX_BYTES[count_ff[PREFIX_IDX_W-1:0]]) begin
               prefix_ok_in = 1'b0;
            end
         end else if (c == CHAR_SLASH) begin
            name_slash_in = 1'b1;
         end
         tail_in = {tail_ff[TAIL_W-9:0], c};

         // general rules and component tracking
         if (count_ff == '0) begin
            if (c != CHAR_SLASH) begin
               flt = 1'b1;
            end
         end else begin
            if (c == CHAR_BSLASH || c < CHAR_SPACE) begin
               flt = 1'b1;
            end
            if (c == CHAR_SLASH) begin
               if (plen == 2'd0 || (pdots && plen != 2'd3)) begin
                  flt = 1'b1;
               end
               plen  = 2'd0;
               pdots = 1'b1;
            end else begin
               if (plen != 2'd3) begin
                  plen = plen + 2'd1;
               end
               if (c != CHAR_DOT) begin
                  pdots = 1'b0;
               end
            end
         end

         // saturating byte count
         if (count_ff < COUNT_W'(MAX_PATH_BYTES)) begin
            count_in = count_ff + COUNT_W'(1);
         end

         // final byte closes the last component and judges the path
         if (step.last) begin
            if (plen == 2'd0 || (pdots && plen != 2'd3)) begin
               flt = 1'b1;
            end
            len = CMP_W'(count_in);
            ok  = !flt && (len < CMP_W'(MAX_PATH_BYTES));
            if (mode == MODE_UPLOAD) begin
               if (!prefix_ok_in || name_slash_in ||
                   len <= CMP_W'(PREFIX_LEN + SUFFIX_LEN) ||
                   len >  CMP_W'(PREFIX_LEN + MAX_NAME_BYTES) ||
                   tail_in != SUFFIX_CODE) begin
                  ok = 1'b0;
               end
            end
            verdict.valid     = 1'b1;
            verdict.valid_res = ok;
         end
      end

      part_len_in  = plen;
      part_dots_in = pdots;
      fault_in     = flt;
   end

   // path state, cleared after each final byte
   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         count_ff      <= '0;
         part_len_ff   <= 2'd0;
         part_dots_ff  <= 1'b1;
         fault_ff      <= 1'b0;
         prefix_ok_ff  <= 1'b1;
         name_slash_ff <= 1'b0;
         tail_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         part_len_ff   <= part_len_in;
         part_dots_ff  <= part_dots_in;
         fault_ff      <= fault_in;
         prefix_ok_ff  <= prefix_ok_in;
         name_slash_ff <= name_slash_in;
         tail_ff       <= tail_in;
      end
   end

endmodule

FILE: hw/rtl/path_safety_validator_top.sv
// path_safety_validator_top: input stage, mode register and result register
// around the path checker. Depends on psv_pkg and psv_checker.
`timescale 1ns / 1ps

// Path safety validator.
// A path enters on the req_ stream one byte per beat, req_tlast marking its
// final byte. For each path one beat leaves on the rsp_ stream, bit 0 of
// rsp_tdata being 1 when the path passes. csr_wen/csr_wdata write the mode:
// 0 general safe path check, 1 html upload path check; write it between paths.
// A byte taken from req_ sits in the input register, is judged by the
// checker as it leaves and, if final, puts its verdict into the result
// register, which drives rsp_tvalid until the verdict beat is taken.
// Throughput: one byte per cycle.
// A held verdict stalls only a final byte; other bytes keep flowing, and a
// new path's bytes are taken while the verdict waits.
// Reset clears the mode to general, the path state and both stages.
module path_safety_validator_top
   import psv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_in
   input  logic       req_tlast,    // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [0] valid_res, [7:1] zero
   input  logic       csr_wen,
   input  logic       csr_wdata     // mode
);

   logic        mode_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_res_ff;
   logic        advance;
   step_type    step;
   verdict_type verdict;

   // input stage moves on unless a verdict would overwrite a waiting one
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = verdict.valid || (rsp_valid_ff && !rsp_tready);

   assign step.valid   = advance;
   assign step.char_in = in_char_ff;
   assign step.last    = in_last_ff;

   psv_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .mode    (mode_ff),
      .step    (step),
      .verdict (verdict)
   );

   // mode register and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GENERAL;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (verdict.valid) begin
         rsp_res_ff <= verdict.valid_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_res_ff};

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for path_safety_validator_top, streaming path bytes in
// and checking each verdict against an in-bench predictor. Depends on psv_pkg.
`timescale 1ns / 1ps

module tb;
   import psv_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] char_in
   logic       req_tlast;    // last
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [0] valid_res, [7:1] zero
   logic       csr_wen;
   logic       csr_wdata;    // mode

   path_safety_validator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // predicts the verdict of each path and holds the verdicts still to come
   class path_verdict_board;
      bit               mode;
      bit [COUNT_W-1:0] seen;
      bit [1:0]         part_len;
      bit               part_dots;
      bit               broken;
      bit               prefix_ok;
      bit               name_slash;
      bit [TAIL_W-1:0]  tail;
      bit [7:0]         verdicts_due[$];
      int               errors;

      function new();
         mode = MODE_GENERAL;
         clear_path();
      endfunction

      function void clear_path();
         seen       = '0;
         part_len   = '0;
         part_dots  = 1'b1;
         broken     = 1'b0;
         prefix_ok  = 1'b1;
         name_slash = 1'b0;
         tail       = '0;
      endfunction

      // judge the component closed by a slash or by the end of the path
      function void close_part();
         if (part_len == 0 || (part_dots && part_len <= 2))
            broken = 1'b1;
         part_len  = '0;
         part_dots = 1'b1;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      // note an accepted path beat
      function void take_byte(bit [7:0] c, bit fin);
         int unsigned name_len;
         bit          pass;
         // upload prefix tracking and slashes inside the file name
         if (seen < PREFIX_LEN) begin
            if (c != PREFIX_BYTES[seen])
               prefix_ok = 1'b0;
         end else if (c == CHAR_SLASH) begin
            name_slash = 1'b1;
         end
         tail = {tail[TAIL_W-9:0], c};
         // general rules
         if (seen == 0) begin
            if (c != CHAR_SLASH)
               broken = 1'b1;
         end else begin
            if (c == CHAR_BSLASH || c < CHAR_SPACE)
               broken = 1'b1;
            if (c == CHAR_SLASH) begin
               close_part();
            end else begin
               if (part_len < 3)
                  part_len++;
               if (c != CHAR_DOT)
                  part_dots = 1'b0;
            end
         end
         if (seen < MAX_PATH_BYTES)
            seen++;
         if (!fin)
            return;
         // final byte: form the verdict
         close_part();
         pass = !broken && (seen < MAX_PATH_BYTES);
         if (mode == MODE_UPLOAD) begin
            name_len = (seen > PREFIX_LEN) ? seen - PREFIX_LEN : 0;
            if (!prefix_ok || seen < PREFIX_LEN || name_slash || name_len <= SUFFIX_LEN ||
                name_len > MAX_NAME_BYTES || tail != SUFFIX_CODE)
               pass = 1'b0;
         end
         verdicts_due.push_back({7'b0, pass});
         clear_path();
      endfunction

      // compare a verdict beat with the oldest prediction
      function void check_verdict(logic [7:0] got);
         bit [7:0] want;
         if (verdicts_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected verdict beat %0h at %0t", got, $realtime);
            return;
         end
         want = verdicts_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("verdict mismatch at %0t: expected %0h got %0h", $realtime, want, got);
         end
      endfunction

      function void close_run();
         if (verdicts_due.size() != 0) begin
            errors += verdicts_due.size();
            $display("%0d verdicts never arrived", verdicts_due.size());
         end
      endfunction
   endclass

   path_verdict_board board;
   bit [7:0]          path_bytes[$];
   int                bytes_sent;
   bit                send_calm;
   bit                sink_calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #(1_000_000);
      $display("FAIL");
      $finish;
   end

   // a byte that trips one of the special rules
   function automatic bit [7:0] odd_byte();
      case ($urandom_range(0, 5))
         0: return CHAR_SLASH;
         1: return CHAR_BSLASH;
         2: return CHAR_DOT;
         3: return CHAR_SPACE;
         4: return 8'h00;
         default: return 8'h1F;
      endcase
   endfunction

   // a byte allowed inside a name component, never a slash
   function automatic bit [7:0] name_char();
      case ($urandom_range(0, 9))
         0: return CHAR_DOT;
         1: return 8'($urandom_range(8'h80, 8'hFF));
         2: return 8'($urandom_range(8'h30, 8'h39));
         3: return 8'($urandom_range(8'h41, 8'h5A));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         path_bytes.push_back(s[i]);
   endfunction

   function automatic void add_prefix();
      for (int i = 0; i < PREFIX_LEN; i++)
         path_bytes.push_back(PREFIX_BYTES[i]);
   endfunction

   // upload path with a file name of the given length ending in the suffix
   function automatic void make_upload(int name_len);
      add_prefix();
      repeat (name_len - SUFFIX_LEN) path_bytes.push_back(name_char());
      for (int k = SUFFIX_LEN - 1; k >= 0; k--)
         path_bytes.push_back(SUFFIX_CODE[8*k +: 8]);
   endfunction

   // general path of random components, now and then with dot components
   function automatic void make_general();
      int parts;
      parts = $urandom_range(1, 6);
      path_bytes.push_back(CHAR_SLASH);
      for (int p = 0; p < parts; p++) begin
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) path_bytes.push_back(CHAR_DOT);
         else
            repeat ($urandom_range(1, 10)) path_bytes.push_back(name_char());
         if (p != parts - 1)
            path_bytes.push_back(CHAR_SLASH);
      end
   endfunction

   // general path of a given total length, no trailing slash
   function automatic void make_long(int total);
      path_bytes.push_back(CHAR_SLASH);
      for (int i = 1; i < total; i++)
         path_bytes.push_back((i % 10 == 0 && i != total - 1) ? CHAR_SLASH : 8'h61);
   endfunction

   function automatic void make_wellformed(bit m);
      if (m == MODE_UPLOAD)
         make_upload(($urandom_range(0, 9) == 0) ? $urandom_range(6, 60)
                                                 : $urandom_range(6, 16));
      else
         make_general();
   endfunction

   // one path beat, with a random hold-off before it
   task automatic send_beat(bit [7:0] c, bit fin);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_byte(c, fin);
      bytes_sent++;
   endtask

   task automatic send_path();
      for (int i = 0; i < path_bytes.size(); i++)
         send_beat(path_bytes[i], i == path_bytes.size() - 1);
   endtask

   task automatic send_text(string s);
      path_bytes = {};
      add_text(s);
      send_path();
   endtask

   // stop sending and wait for every verdict plus the pipeline depth
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_wen   <= 1'b0;
      board.mode = m;
   endtask

   // random paths in one mode until the byte budget is spent
   task automatic run_phase(bit m, int budget);
      int start;
      int pick;
      int pos;
      start = bytes_sent;
      write_mode(m);
      while (bytes_sent - start < budget) begin
         path_bytes = {};
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            make_wellformed(m);
         end else if (pick < 55) begin
            make_wellformed(!m);
         end else if (pick < 80) begin
            // variant of a generated path with one random change that may break it
            make_wellformed($urandom_range(0, 1));
            pos = $urandom_range(0, path_bytes.size() - 1);
            case ($urandom_range(0, 4))
               0: path_bytes[pos] = 8'($urandom_range(0, 255));
               1: path_bytes[pos] = odd_byte();
               2: if (path_bytes.size() > 1) path_bytes.delete(pos);
               3: path_bytes.push_back(CHAR_SLASH);
               default: path_bytes = path_bytes[0:pos];
            endcase
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 30))
               path_bytes.push_back(($urandom_range(0, 3) == 0) ? odd_byte()
                                                                 : 8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 1) == 0) begin
            make_long($urandom_range(250, 270));
         end else begin
            make_upload($urandom_range(228, 245));
         end
         send_path();
      end
      settle();
   endtask

   // verdict sink with random back-pressure
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 29) == 0)
            sink_calm = !sink_calm;
         gap = sink_calm ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_verdict(rsp_tdata);
      end
   end

   // reset, directed paths, random phases, end of run
   initial begin
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wen    = 1'b0;
      csr_wdata  = MODE_GENERAL;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // general mode corner cases
      write_mode(MODE_GENERAL);
      send_text("/");
      send_text("/a");
      send_text("a/b");
      send_text("/a/");
      send_text("//a");
      send_text("/./a");
      send_text("/../a");
      send_text("/.../b");
      send_text("/a\\b");
      path_bytes = '{CHAR_SLASH, 8'h61, 8'h00, 8'h62};
      send_path();
      path_bytes = '{CHAR_SLASH, 8'h61, 8'h1F};
      send_path();
      path_bytes = '{CHAR_SLASH, CHAR_SPACE, 8'h7F, 8'hFF};
      send_path();
      // length limit: just under, at, and well past it
      path_bytes = {};
      make_long(MAX_PATH_BYTES - 1);
      send_path();
      path_bytes = {};
      make_long(MAX_PATH_BYTES);
      send_path();
      path_bytes = {};
      make_long(MAX_PATH_BYTES + 44);
      send_path();
      settle();

      // upload mode corner cases
      write_mode(MODE_UPLOAD);
      path_bytes = {};
      add_prefix();
      add_text("a.html");
      send_path();
      path_bytes = {};
      add_prefix();
      add_text(".html");
      send_path();
      path_bytes = {};
      add_prefix();
      add_text("x/a.html");
      send_path();
      path_bytes = {};
      add_prefix();
      add_text("a.HTML");
      send_path();
      send_text("/short");
      path_bytes = {};
      add_prefix();
      path_bytes[5] = 8'h2D;
      add_text("a.html");
      send_path();
      // name length bringing the path to just under and to the length limit
      path_bytes = {};
      make_upload(MAX_PATH_BYTES - 1 - PREFIX_LEN);
      send_path();
      path_bytes = {};
      make_upload(MAX_PATH_BYTES - PREFIX_LEN);
      send_path();
      settle();

      // random part, alternating modes
      run_phase(MODE_UPLOAD, 80);
      run_phase(MODE_GENERAL, 80);
      run_phase(MODE_UPLOAD, 80);
      run_phase(MODE_GENERAL, 80);

      repeat (8) @(posedge clock);
      board.close_run();
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
